/* hdl/iidl_pkg.sv */
// Shared types and constants for the indexed insert/delete list.
`timescale 1ns / 1ps

package iidl_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int MODE_W   = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 8;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_BITS  = MODE_W + POS_W + VALUE_W;
  localparam int OUT_BITS = VALUE_W + STATUS_W + FILL_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_WRITE,
    S_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the input word
    logic k_init;   // start the move index
    logic rd_src;   // read the entry to be moved
    logic rd_pos;   // read the entry at position
    logic mv_wr;    // write the moved entry, step the index
    logic wr_val;   // write the new value at position
    logic commit;   // update count, load the result register
  } iidl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_e   mode;
    status_e status;
    logic    no_move;
    logic    last_move;
    logic    out_free;
  } iidl_stat_t;

endpackage

/* hdl/iidl_ctrl.sv */
// Sequencer for the list: decides, steps the entry moves and hands off the result.
`timescale 1ns / 1ps

module iidl_ctrl
  import iidl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  iidl_stat_t stat_i,
  output iidl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.status != ST_OK) begin
          state_d = S_RESP;
        end else begin
          unique case (stat_i.mode)
            MODE_INSERT: begin
              cmd_o.k_init = 1'b1;
              state_d      = stat_i.no_move ? S_WRITE : S_MOVE_RD;
            end
            MODE_DELETE: begin
              cmd_o.k_init = 1'b1;
              state_d      = stat_i.no_move ? S_RESP : S_MOVE_RD;
            end
            MODE_READ: begin
              cmd_o.rd_pos = 1'b1;
              state_d      = S_RESP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_MOVE_RD: begin
        cmd_o.rd_src = 1'b1;
        state_d      = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd_o.mv_wr = 1'b1;
        if (!stat_i.last_move) begin
          state_d = S_MOVE_RD;
        end else if (stat_i.mode == MODE_INSERT) begin
          state_d = S_WRITE;
        end else begin
          state_d = S_RESP;
        end
      end
      S_WRITE: begin
        cmd_o.wr_val = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/iidl_dp.sv */
// Datapath: entry memory, fill count, move index, request and result registers.
`timescale 1ns / 1ps

module iidl_dp
  import iidl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IN_W-1:0]  in_data_i,
  input  iidl_cmd_t        cmd_i,
  output iidl_stat_t       stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] out_data_o
);

  logic [VALUE_W-1:0] mem [CAPACITY];

  mode_e              mode_q;
  logic [POS_W-1:0]   pos_q;
  logic [VALUE_W-1:0] value_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   k_q;
  logic [VALUE_W-1:0] rdata_q;

  logic               out_valid_q;
  logic [VALUE_W-1:0] out_value_q;
  status_e            out_status_q;
  logic [FILL_W-1:0]  out_fill_q;

  logic [CMP_W-1:0]   pos_ext, cnt_ext;
  logic [CNT_W-1:0]   src_idx;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  status_e            status;

  assign pos_ext = CMP_W'(pos_q);
  assign cnt_ext = CMP_W'(count_q);

  always_comb begin
    status = ST_OK;
    case (mode_q)
      MODE_INSERT: begin
        if (count_q == CNT_W'(CAPACITY)) begin
          status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end
      end
      MODE_DELETE: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end
      end
      MODE_READ: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // insert walks down from the count, delete walks up from the position
  assign src_idx = (mode_q == MODE_INSERT) ? (k_q - CNT_W'(1)) : (k_q + CNT_W'(1));

  always_comb begin
    stat_o.mode     = mode_q;
    stat_o.status   = status;
    stat_o.out_free = !out_valid_q || out_ready_i;
    if (mode_q == MODE_INSERT) begin
      stat_o.no_move   = (cnt_ext == pos_ext);
      stat_o.last_move = (CMP_W'(k_q - CNT_W'(1)) == pos_ext);
    end else begin
      stat_o.no_move   = ((pos_ext + CMP_W'(1)) == cnt_ext);
      stat_o.last_move = ((k_q + CNT_W'(2)) == count_q);
    end
  end

  assign rd_addr = cmd_i.rd_pos ? ADDR_W'(pos_q) : src_idx[ADDR_W-1:0];
  assign wr_addr = cmd_i.wr_val ? ADDR_W'(pos_q) : k_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_pos || cmd_i.rd_src) begin
      rdata_q <= mem[rd_addr];
    end
    if (cmd_i.wr_val || cmd_i.mv_wr) begin
      mem[wr_addr] <= cmd_i.wr_val ? value_q : rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_e'(in_data_i[MODE_W-1:0]);
      pos_q   <= in_data_i[MODE_W +: POS_W];
      value_q <= in_data_i[MODE_W+POS_W +: VALUE_W];
    end
    if (cmd_i.k_init) begin
      k_q <= (mode_q == MODE_INSERT) ? count_q : CNT_W'(pos_q);
    end else if (cmd_i.mv_wr) begin
      k_q <= src_idx;
    end
  end

  always_comb begin
    count_d = count_q;
    if (status == ST_OK) begin
      case (mode_q)
        MODE_INSERT: count_d = count_q + CNT_W'(1);
        MODE_DELETE: count_d = count_q - CNT_W'(1);
        MODE_CLEAR:  count_d = '0;
        default:     count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_value_q  <= (mode_q == MODE_READ && status == ST_OK) ? rdata_q : '0;
      out_status_q <= status;
      out_fill_q   <= FILL_W'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = OUT_W'({out_fill_q, out_status_q, out_value_q});

endmodule

/* hdl/indexed_insert_delete_list.sv */
// Top level of the indexed insert/delete list.
`timescale 1ns / 1ps

// Ordered list of up to 128 signed words held in a single-port-write memory with a
// fill count. Each input word is one request (insert, delete, read or clear) and gives
// exactly one result word with status and the count after the request. One request is
// handled at a time; the moves of an insert or delete go through the memory one entry
// at a time (read, then write). The result sits in an output register, so the next
// request is taken while the previous result waits. Memory contents need no clearing
// after reset; only entries below the count are ever read.
module indexed_insert_delete_list
  import iidl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [1:0] mode, [8:2] position, [40:9] value, [47:41] zero
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // [31:0] read_value, [33:32] status, [41:34] fill_count, [47:42] zero
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  iidl_cmd_t  cmd;
  iidl_stat_t stat;

  iidl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  iidl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

/* hdl/iidl_checker.sv */
// Port-level checks on the list, bound to the top level.
`timescale 1ns / 1ps

module iidl_checker
  import iidl_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic [IN_W-1:0]  s_axis_tdata_i,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o
);

  logic [VALUE_W-1:0]  rd_val;
  logic [STATUS_W-1:0] st;
  logic [FILL_W-1:0]   fill;

  assign rd_val = m_axis_tdata_o[VALUE_W-1:0];
  assign st     = m_axis_tdata_o[VALUE_W +: STATUS_W];
  assign fill   = m_axis_tdata_o[VALUE_W+STATUS_W +: FILL_W];

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // one request at a time
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken twice in a row");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st != ST_OK |-> rd_val == '0)
    else $error("refused request carries data");

  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> fill <= FILL_W'(CAPACITY))
    else $error("fill count above capacity");

  // full only reported when the list holds capacity entries
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == ST_FULL |-> fill == FILL_W'(CAPACITY))
    else $error("full status with spare room");

endmodule

bind indexed_insert_delete_list iidl_checker u_iidl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

/* tb/tb.sv */
// Self-checking testbench for the indexed insert/delete list.
`timescale 1ns / 1ps

module tb;
  import iidl_pkg::*;

  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int SETTLE      = 300;   // quiet time after the last result is drained
  localparam int STALL_LIMIT = 4000;  // cycles without any handshake
  localparam int N_ITEMS     = 550;
  localparam int QUIET_TAIL  = 60;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    status_e            status;
    logic [FILL_W-1:0]  fill;
  } result_t;

  typedef struct {
    mode_e              mode;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    result_t            res;
  } row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_tvalid = 1'b0;
  logic [IN_W-1:0] s_tdata = '0;
  logic            m_tready = 1'b0;
  logic            s_axis_tready_o;
  logic            m_axis_tvalid_o;
  logic [OUT_W-1:0] m_axis_tdata_o;

  indexed_insert_delete_list i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // shadow of the list
  logic [VALUE_W-1:0] list_mem [CAPACITY];
  int                 list_count = 0;
  int                 peak_count = 0;

  result_t result_q[$];
  row_t    plan[$];

  int errors = 0;
  int n_sent = 0;
  int n_mode[4];
  int n_status[4];
  int idle_cycles = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t list_apply(input mode_e m, input int pos,
                                         input logic [VALUE_W-1:0] val);
    result_t r;
    int      k;
    r.read_value = '0;
    r.status     = ST_OK;
    case (m)
      MODE_INSERT: begin
        if (list_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (pos > list_count) begin
          r.status = ST_RANGE;
        end else begin
          for (k = list_count; k > pos; k--) list_mem[k] = list_mem[k-1];
          list_mem[pos] = val;
          list_count++;
        end
      end
      MODE_DELETE: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          for (k = pos; k + 1 < list_count; k++) list_mem[k] = list_mem[k+1];
          list_count--;
        end
      end
      MODE_READ: begin
        if (pos >= list_count) r.status = ST_RANGE;
        else                   r.read_value = list_mem[pos];
      end
      default: list_count = 0;
    endcase
    if (list_count > peak_count) peak_count = list_count;
    r.fill = FILL_W'(list_count);
    return r;
  endfunction

  function automatic row_t mk_row(input mode_e m, input int pos, input logic [31:0] val,
                                  input bit typed, input logic [31:0] rd,
                                  input status_e st, input int fill);
    row_t r;
    r.mode  = m;
    r.pos   = POS_W'(pos);
    r.value = val;
    r.typed = typed;
    r.res.read_value = rd;
    r.res.status     = st;
    r.res.fill       = FILL_W'(fill);
    return r;
  endfunction

  // offer one request word, hold it until taken, then book its expected result
  task automatic send_req(input mode_e m, input logic [POS_W-1:0] pos,
                          input logic [VALUE_W-1:0] val, input bit typed,
                          input result_t typed_res);
    result_t r;
    s_tdata  <= {{(IN_W-IN_BITS){1'b0}}, val, pos, m};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = list_apply(m, pos, val);
    if (typed) r = typed_res;
    result_q.push_back(r);
    n_sent++;
    n_mode[m]++;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // random request, positions mostly within the current fill
  task automatic send_random();
    mode_e m;
    int    pos;
    int    pick;
    pick = $urandom_range(0, 19);
    if (pick < 8)       m = MODE_INSERT;
    else if (pick < 13) m = MODE_DELETE;
    else if (pick < 19) m = MODE_READ;
    else                m = MODE_CLEAR;
    pos = $urandom_range(0, CAPACITY - 1);
    if ($urandom_range(0, 9) < 7) begin
      if (m == MODE_INSERT && list_count < CAPACITY)
        pos = $urandom_range(0, list_count);
      else if (m != MODE_INSERT && list_count > 0)
        pos = $urandom_range(0, list_count - 1);
    end
    send_req(m, POS_W'(pos), $urandom, 1'b0, '0);
  endtask

  task automatic bulk_load(input int n);
    send_req(MODE_CLEAR, POS_W'($urandom), $urandom, 1'b0, '0);
    repeat (n) begin
      send_req(MODE_INSERT, POS_W'(list_count), rand_value(), 1'b0, '0);
    end
  endtask

  task automatic drain();
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (m_axis_tvalid_o && m_tready) begin
      got.read_value = m_axis_tdata_o[31:0];
      got.status     = status_e'(m_axis_tdata_o[33:32]);
      got.fill       = m_axis_tdata_o[41:34];
      n_status[got.status]++;
      if (result_q.size() == 0) begin
        $error("unexpected result word: read_value %h status %0d fill_count %0d",
               got.read_value, got.status, got.fill);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (got.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, got.read_value);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.fill !== want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, got.fill);
          errors++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver back-pressure
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int i;
    int n;

    // empty list, extremes, and the refused cases
    plan.push_back(mk_row(MODE_READ,   0,   32'h0000_0000, 1, 32'h0, ST_RANGE, 0));
    plan.push_back(mk_row(MODE_DELETE, 0,   32'h0000_0000, 1, 32'h0, ST_EMPTY, 0));
    plan.push_back(mk_row(MODE_DELETE, 127, 32'hFFFF_FFFF, 1, 32'h0, ST_EMPTY, 0));
    plan.push_back(mk_row(MODE_INSERT, 1,   32'h1234_5678, 1, 32'h0, ST_RANGE, 0));
    plan.push_back(mk_row(MODE_INSERT, 0,   32'h7FFF_FFFF, 1, 32'h0, ST_OK,    1));
    plan.push_back(mk_row(MODE_INSERT, 0,   32'h8000_0000, 1, 32'h0, ST_OK,    2));
    plan.push_back(mk_row(MODE_INSERT, 2,   32'hFFFF_FFFF, 1, 32'h0, ST_OK,    3));
    plan.push_back(mk_row(MODE_INSERT, 127, 32'h0000_0001, 1, 32'h0, ST_RANGE, 3));
    plan.push_back(mk_row(MODE_READ,   0,   32'h0, 1, 32'h8000_0000, ST_OK, 3));
    plan.push_back(mk_row(MODE_READ,   1,   32'h0, 1, 32'h7FFF_FFFF, ST_OK, 3));
    plan.push_back(mk_row(MODE_READ,   2,   32'h0, 1, 32'hFFFF_FFFF, ST_OK, 3));
    plan.push_back(mk_row(MODE_READ,   3,   32'h0, 1, 32'h0, ST_RANGE, 3));
    plan.push_back(mk_row(MODE_READ,   127, 32'h0, 1, 32'h0, ST_RANGE, 3));
    plan.push_back(mk_row(MODE_DELETE, 3,   32'h0, 1, 32'h0, ST_RANGE, 3));
    plan.push_back(mk_row(MODE_INSERT, 1,   32'h0000_0000, 0, 32'h0, ST_OK, 0));
    plan.push_back(mk_row(MODE_INSERT, 3,   32'h5A5A_A5A5, 0, 32'h0, ST_OK, 0));
    plan.push_back(mk_row(MODE_READ,   1,   32'h0, 0, 32'h0, ST_OK, 0));
    plan.push_back(mk_row(MODE_DELETE, 1,   32'h0, 0, 32'h0, ST_OK, 0));
    plan.push_back(mk_row(MODE_DELETE, 0,   32'h0, 0, 32'h0, ST_OK, 0));
    plan.push_back(mk_row(MODE_READ,   2,   32'h0, 0, 32'h0, ST_OK, 0));
    plan.push_back(mk_row(MODE_CLEAR,  127, 32'hFFFF_FFFF, 1, 32'h0, ST_OK, 0));
    plan.push_back(mk_row(MODE_CLEAR,  0,   32'h0000_0000, 1, 32'h0, ST_OK, 0));
    plan.push_back(mk_row(MODE_READ,   0,   32'h0, 1, 32'h0, ST_RANGE, 0));
    plan.push_back(mk_row(MODE_INSERT, 0,   32'hDEAD_BEEF, 1, 32'h0, ST_OK, 1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    foreach (plan[j]) send_req(plan[j].mode, plan[j].pos, plan[j].value,
                               plan[j].typed, plan[j].res);

    // fill to capacity, then hit the edges of a full list
    tx_gap_pct   = 5;
    rx_stall_pct = 5;
    bulk_load(CAPACITY);
    send_req(MODE_INSERT, POS_W'(0), 32'h1, 1'b0, '0);
    send_req(MODE_INSERT, POS_W'(CAPACITY - 1), 32'h2, 1'b0, '0);
    send_req(MODE_READ, POS_W'(CAPACITY - 1), '0, 1'b0, '0);
    send_req(MODE_READ, POS_W'(0), '0, 1'b0, '0);
    send_req(MODE_DELETE, POS_W'(0), '0, 1'b0, '0);
    send_req(MODE_INSERT, POS_W'(0), rand_value(), 1'b0, '0);
    send_req(MODE_DELETE, POS_W'(CAPACITY - 1), '0, 1'b0, '0);
    send_req(MODE_READ, POS_W'(CAPACITY - 1), '0, 1'b0, '0);

    // receiver holds off while words keep coming, then the sender waits it out
    tx_gap_pct = 0;
    hold_req   = 1'b1;
    repeat (12) send_random();
    s_tvalid <= 1'b0;
    drain();

    while (n_sent < N_ITEMS) begin
      if (n_sent >= N_ITEMS - QUIET_TAIL) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       tx_gap_pct = 0;
          1:       tx_gap_pct = 10;
          default: tx_gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       rx_stall_pct = 0;
          1:       rx_stall_pct = 10;
          default: rx_stall_pct = 40;
        endcase
      end
      if ($urandom_range(0, 2) == 0) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(64, CAPACITY)
                                        : $urandom_range(1, 24);
        bulk_load(n);
      end
      n = $urandom_range(20, 40);
      for (i = 0; i < n; i++) send_random();
      if ($urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        drain();
      end
    end

    s_tvalid <= 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk_i);

    $display("tb: %0d requests: %0d insert, %0d delete, %0d read, %0d clear",
             n_sent, n_mode[MODE_INSERT], n_mode[MODE_DELETE], n_mode[MODE_READ],
             n_mode[MODE_CLEAR]);
    $display("tb: results ok %0d, full %0d, empty %0d, out of range %0d; peak fill %0d",
             n_status[ST_OK], n_status[ST_FULL], n_status[ST_EMPTY], n_status[ST_RANGE],
             peak_count);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* indexed_insert_delete_list.f */
hdl/iidl_pkg.sv
hdl/iidl_ctrl.sv
hdl/iidl_dp.sv
hdl/indexed_insert_delete_list.sv
hdl/iidl_checker.sv
tb/tb.sv
